// ===== sv/lfsc_pkg.sv =====
// ----------------------------------------------------------------------------
// LQR funnel select control package
// Shared types, table layout constants and small arithmetic helpers.
// ----------------------------------------------------------------------------
package lfsc_pkg;

  localparam int unsigned FunnelW = 4;
  localparam int unsigned WordW   = 5;
  localparam int unsigned AddrW   = FunnelW + WordW;
  localparam int unsigned MemDepth = 1 << AddrW;
  localparam int unsigned MaxFunnels = 16;

  localparam logic [WordW-1:0] W_RADIUS   = 5'd0;
  localparam logic [WordW-1:0] W_CENTER   = 5'd1;
  localparam logic [WordW-1:0] W_CTR_LAST = 5'd4;
  localparam logic [WordW-1:0] W_NOMINAL  = 5'd5;
  localparam logic [WordW-1:0] W_GAIN     = 5'd7;
  localparam logic [WordW-1:0] W_GAIN_LAST = 5'd14;
  localparam logic [WordW-1:0] W_COST     = 5'd15;
  localparam logic [WordW-1:0] W_COST_LAST = 5'd30;
  localparam logic [WordW-1:0] W_TOTAL    = 5'd31;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic CFG_FUNNEL_COUNT = 1'b0;
  localparam logic CFG_PASSTHROUGH  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EDRAIN,
    S_FIN,
    S_FDRAIN,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_RAD,
    K_CTR,
    K_NOM,
    K_GAIN,
    K_COST
  } kind_t;

  typedef struct packed {
    logic       vld;
    kind_t      kind;
    logic [1:0] i;
    logic [1:0] j;
  } tag_t;

  function automatic tag_t word_tag(input logic [WordW-1:0] w);
    tag_t             t;
    logic [WordW-1:0] o;
    t = '0;
    t.vld = 1'b1;
    o = '0;
    if (w == W_RADIUS) begin
      t.kind = K_RAD;
    end else if (w < W_NOMINAL) begin
      o = w - W_CENTER;
      t.kind = K_CTR;
      t.i = o[1:0];
    end else if (w < W_GAIN) begin
      o = w - W_NOMINAL;
      t.kind = K_NOM;
      t.i = o[1:0];
    end else if (w < W_COST) begin
      o = w - W_GAIN;
      t.kind = K_GAIN;
      t.i = o[3:2];
      t.j = o[1:0];
    end else begin
      o = w - W_COST;
      t.kind = K_COST;
      t.i = o[3:2];
      t.j = o[1:0];
    end
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [51:0] v);
    if (v > 52'sd32767) begin
      return 16'sh7fff;
    end else if (v < -52'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

// ===== sv/lqr_funnel_select_control.sv =====
// ----------------------------------------------------------------------------
// LQR funnel select control
// Holds a table of LQR funnels in one word memory, picks the funnel of least
// quadratic cost that contains the measured state and drives nominal - K*d.
// ----------------------------------------------------------------------------
//  channel | dir | handshake                  | payload
//  in_     | in  | in_tvalid / in_tready      | tuser command, tdata load/step
//  out_    | out | out_tvalid / out_tready    | tdata control, found, funnel
//  cfg_    | in  | cfg_we                     | cfg_index, cfg_wdata
//
// A step reads 21 table words per funnel (radius, centre and cost words) on the
// single read port and waits for the multiplier drain; if a funnel was hit it
// then rereads 14 words (centre, nominal, gain) of the chosen one. In passthrough
// a step outputs the source control; with no funnels or no hit it outputs zero.
// Reset clears control state only; table words are undefined until loaded.
// Input is taken only while the sequencer is idle; a held result stalls the
// next step's completion, not its acceptance.
// ----------------------------------------------------------------------------
module lqr_funnel_select_control (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [0:0]   in_tuser,   // command
  // funnel_index, word_index, word_value, state_0..3, source_control_0..1
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // control_0, control_1, found, chosen_funnel
  output logic [39:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [4:0]   cfg_wdata
);

  localparam int unsigned AW = lfsc_pkg::AddrW;

  lfsc_pkg::state_t state_r, state_nxt;
  logic [4:0] wc_r, wc_nxt;
  logic [3:0] f_r, f_nxt;

  logic [4:0] fcount_r;
  logic       pass_r;
  logic [4:0] n_r;

  logic signed [15:0] x_r [4];
  logic signed [31:0] d_r [4];
  logic signed [31:0] rad_r;

  logic [31:0] mem [lfsc_pkg::MemDepth];
  logic [31:0] mem_q_r;
  lfsc_pkg::tag_t tb_r, tc_r;
  lfsc_pkg::tag_t issue_tag;

  logic signed [63:0] prod_r, prod2_r;
  logic signed [49:0] t_acc_r, q_acc_r, best_q_r;
  logic signed [31:0] t_fin_r;
  logic               dv_r, ev_r;
  logic [1:0]         di_r, ei_r;
  logic signed [51:0] v_r [2];
  logic               done_r;
  logic               found_r;
  logic [3:0]         best_r;

  logic signed [15:0] res_c0_r, res_c1_r;
  logic               res_found_r;
  logic [3:0]         res_best_r;
  logic               out_tvalid_r;
  logic [39:0]        out_tdata_r;

  logic        in_fire, step_go, load_go, issue, out_free, hit, last_f, consume;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [3:0]  fsel;
  logic signed [49:0] q_sum, t_sum;
  logic signed [47:0] prod_sh, prod2_sh;
  logic signed [32:0] dif;

  assign in_tready = (state_r == lfsc_pkg::S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign step_go   = in_fire & (in_tuser[0] == lfsc_pkg::CMD_STEP);
  assign load_go   = in_fire & (in_tuser[0] == lfsc_pkg::CMD_LOAD);
  assign out_free  = ~out_tvalid_r | out_tready;
  assign fsel      = (state_r == lfsc_pkg::S_FIN) ? best_r : f_r;
  assign rd_addr   = {fsel, wc_r};
  assign wr_addr   = {in_tdata[3:0], in_tdata[8:4]};
  assign issue_tag = lfsc_pkg::word_tag(wc_r);
  assign last_f    = ({1'b0, f_r} + 5'd1) == n_r;
  assign hit       = (q_acc_r < 50'(rad_r)) && (~found_r || (q_acc_r < best_q_r));
  assign consume   = done_r && (state_r == lfsc_pkg::S_EDRAIN ||
                                state_r == lfsc_pkg::S_FDRAIN);
  assign prod_sh   = prod_r[63:16];
  assign prod2_sh  = prod2_r[63:16];
  assign t_sum     = ((tc_r.j == 2'd0) ? 50'sd0 : t_acc_r) + 50'(prod_sh);
  assign q_sum     = ((ei_r == 2'd0) ? 50'sd0 : q_acc_r) + 50'(prod2_sh);
  assign dif       = 33'(signed'({x_r[tb_r.i], 8'h00})) - 33'(signed'(mem_q_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfsc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    wc_nxt = wc_r;
    f_nxt = f_r;
    issue = 1'b0;
    unique case (state_r)
      lfsc_pkg::S_IDLE: begin
        if (step_go) begin
          wc_nxt = lfsc_pkg::W_RADIUS;
          f_nxt = '0;
          if (pass_r || fcount_r == 5'd0) begin
            state_nxt = lfsc_pkg::S_OUT;
          end else begin
            state_nxt = lfsc_pkg::S_EVAL;
          end
        end
      end
      lfsc_pkg::S_EVAL: begin
        issue = 1'b1;
        if (wc_r == lfsc_pkg::W_CTR_LAST) begin
          wc_nxt = lfsc_pkg::W_COST;
        end else if (wc_r == lfsc_pkg::W_COST_LAST) begin
          state_nxt = lfsc_pkg::S_EDRAIN;
        end else begin
          wc_nxt = wc_r + 5'd1;
        end
      end
      lfsc_pkg::S_EDRAIN: begin
        if (done_r) begin
          if (!last_f) begin
            f_nxt = f_r + 4'd1;
            wc_nxt = lfsc_pkg::W_RADIUS;
            state_nxt = lfsc_pkg::S_EVAL;
          end else if (found_r || hit) begin
            wc_nxt = lfsc_pkg::W_CENTER;
            state_nxt = lfsc_pkg::S_FIN;
          end else begin
            state_nxt = lfsc_pkg::S_OUT;
          end
        end
      end
      lfsc_pkg::S_FIN: begin
        issue = 1'b1;
        if (wc_r == lfsc_pkg::W_GAIN_LAST) begin
          state_nxt = lfsc_pkg::S_FDRAIN;
        end else begin
          wc_nxt = wc_r + 5'd1;
        end
      end
      lfsc_pkg::S_FDRAIN: begin
        if (done_r) begin
          state_nxt = lfsc_pkg::S_OUT;
        end
      end
      lfsc_pkg::S_OUT: begin
        if (out_free) begin
          state_nxt = lfsc_pkg::S_IDLE;
        end
      end
      default: state_nxt = lfsc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_go && in_tdata[8:4] < lfsc_pkg::W_TOTAL) begin
      mem[wr_addr] <= in_tdata[40:9];
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcount_r <= '0;
      pass_r <= 1'b1;
      tb_r <= '0;
      tc_r <= '0;
      dv_r <= 1'b0;
      ev_r <= 1'b0;
      done_r <= 1'b0;
      found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
      wc_r <= '0;
      f_r <= '0;
    end else begin
      wc_r <= wc_nxt;
      f_r <= f_nxt;
      if (cfg_we) begin
        if (cfg_index[0] == lfsc_pkg::CFG_FUNNEL_COUNT) begin
          fcount_r <= cfg_wdata;
        end else begin
          pass_r <= cfg_wdata[0];
        end
      end
      tb_r <= issue ? issue_tag : '0;
      tc_r <= (tb_r.vld && (tb_r.kind == lfsc_pkg::K_COST ||
                            tb_r.kind == lfsc_pkg::K_GAIN)) ? tb_r : '0;
      dv_r <= tc_r.vld && tc_r.kind == lfsc_pkg::K_COST && tc_r.j == 2'd3;
      ev_r <= dv_r;
      if (consume) begin
        done_r <= 1'b0;
      end else if ((ev_r && ei_r == 2'd3) ||
                   (tc_r.vld && tc_r.kind == lfsc_pkg::K_GAIN &&
                    tc_r.i == 2'd1 && tc_r.j == 2'd3)) begin
        done_r <= 1'b1;
      end
      if (step_go) begin
        found_r <= 1'b0;
      end else if (state_r == lfsc_pkg::S_EDRAIN && done_r && hit) begin
        found_r <= 1'b1;
      end
      if (state_r == lfsc_pkg::S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      x_r[0] <= in_tdata[56:41];
      x_r[1] <= in_tdata[72:57];
      x_r[2] <= in_tdata[88:73];
      x_r[3] <= in_tdata[104:89];
      n_r <= (fcount_r > 5'(lfsc_pkg::MaxFunnels)) ? 5'(lfsc_pkg::MaxFunnels) : fcount_r;
      res_found_r <= 1'b0;
      res_best_r <= '0;
      if (pass_r) begin
        res_c0_r <= in_tdata[120:105];
        res_c1_r <= in_tdata[136:121];
      end else begin
        res_c0_r <= '0;
        res_c1_r <= '0;
      end
    end
    if (tb_r.vld) begin
      unique case (tb_r.kind)
        lfsc_pkg::K_RAD:  rad_r <= mem_q_r;
        lfsc_pkg::K_CTR:  d_r[tb_r.i] <= lfsc_pkg::sat32(52'(dif));
        lfsc_pkg::K_NOM:  v_r[tb_r.i[0]] <= 52'(signed'(mem_q_r));
        lfsc_pkg::K_GAIN,
        lfsc_pkg::K_COST: prod_r <= 64'(signed'(mem_q_r)) * 64'(d_r[tb_r.j]);
        default:          rad_r <= rad_r;
      endcase
    end
    if (tc_r.vld) begin
      if (tc_r.kind == lfsc_pkg::K_COST) begin
        t_acc_r <= t_sum;
        t_fin_r <= lfsc_pkg::sat32(52'(t_sum));
        di_r <= tc_r.i;
      end else begin
        v_r[tc_r.i[0]] <= v_r[tc_r.i[0]] - 52'(prod_sh);
      end
    end
    if (dv_r) begin
      prod2_r <= 64'(d_r[di_r]) * 64'(t_fin_r);
      ei_r <= di_r;
    end
    if (ev_r) begin
      q_acc_r <= q_sum;
    end
    if (state_r == lfsc_pkg::S_EDRAIN && done_r && hit) begin
      best_q_r <= q_acc_r;
      best_r <= f_r;
    end
    if (state_r == lfsc_pkg::S_FDRAIN && done_r) begin
      res_c0_r <= lfsc_pkg::sat16(v_r[0] >>> 8);
      res_c1_r <= lfsc_pkg::sat16(v_r[1] >>> 8);
      res_found_r <= 1'b1;
      res_best_r <= best_r;
    end
    if (state_r == lfsc_pkg::S_OUT && out_free) begin
      out_tdata_r <= {3'b000, res_best_r, res_found_r, res_c1_r, res_c0_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== tb/lqr_funnel_select_control_test.sv =====
// ----------------------------------------------------------------------------
// LQR funnel select control testbench
// Checks table loads, funnel selection, gain control and passthrough. A
// directed table (including a full table fill) is followed by random phases
// that aim most steps into loaded funnels. Each result is checked against
// a prediction or directed value; both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module lqr_funnel_select_control_test;

  localparam int ROW_STEP  = 0;
  localparam int ROW_LOAD  = 1;
  localparam int ROW_CFG   = 2;
  localparam int ROW_FILL  = 3;
  localparam int ROW_CLONE = 4;

  localparam int ItemTarget = 1850;
  localparam int SettleCycles = 600;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic             cmd;
    logic [3:0]       fidx;
    logic [4:0]       widx;
    logic [31:0]      wval;
    logic [3:0][15:0] st;
    logic [1:0][15:0] sc;
  } item_t;

  localparam int ItemW = $bits(item_t);

  typedef struct packed {
    logic [3:0]  chosen;
    logic        found;
    logic [15:0] c1;
    logic [15:0] c0;
  } result_t;

  typedef struct {
    int      kind;
    item_t   it;
    bit      has_exp;
    result_t res;
    int      aim;
    int      a;
    int      b;
  } row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [0:0]   in_tuser;   // command
  // funnel_index, word_index, word_value, state_0..3, source_control_0..1
  logic [143:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  // control_0, control_1, found, chosen_funnel
  logic [39:0]  out_tdata;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [4:0]   cfg_wdata;

  lqr_funnel_select_control dut (.*);

  logic signed [31:0] rad_tab [16];
  logic signed [31:0] ctr_tab [16][4];
  logic signed [31:0] nom_tab [16][2];
  logic signed [31:0] gain_tab [16][2][4];
  logic signed [31:0] cost_tab [16][4][4];
  int unsigned funnel_cnt;
  bit          pass_mode;

  result_t control_q [$];
  row_t    rows [$];
  int      fail_cnt;
  int      item_cnt;
  longint  cyc = 0;
  bit      hold_req;
  int      burst_left;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void funnel_delta(int f, item_t it, output longint d [4]);
    for (int i = 0; i < 4; i++) begin
      d[i] = clamp64(longint'($signed(it.st[i])) * 256 - longint'(ctr_tab[f][i]),
                     -64'sd2147483648, 64'sd2147483647);
    end
  endfunction

  function automatic result_t predict_control(item_t it);
    result_t r;
    longint  d [4];
    longint  q, t, v, best_q;
    int      n, best;
    bit      hit;
    r = '0;
    best_q = 0;
    best = 0;
    hit = 0;
    if (pass_mode) begin
      r.c0 = it.sc[0];
      r.c1 = it.sc[1];
      return r;
    end
    n = funnel_cnt > 16 ? 16 : funnel_cnt;
    for (int f = 0; f < n; f++) begin
      funnel_delta(f, it, d);
      q = 0;
      for (int i = 0; i < 4; i++) begin
        t = 0;
        for (int j = 0; j < 4; j++) t += (longint'(cost_tab[f][i][j]) * d[j]) >>> 16;
        t = clamp64(t, -64'sd2147483648, 64'sd2147483647);
        q += (d[i] * t) >>> 16;
      end
      if (q < longint'(rad_tab[f]) && (!hit || q < best_q)) begin
        hit = 1;
        best_q = q;
        best = f;
      end
    end
    if (!hit) return r;
    funnel_delta(best, it, d);
    for (int k = 0; k < 2; k++) begin
      v = nom_tab[best][k];
      for (int j = 0; j < 4; j++) v -= (longint'(gain_tab[best][k][j]) * d[j]) >>> 16;
      v = clamp64(v >>> 8, -32768, 32767);
      if (k == 0) r.c0 = v[15:0];
      else r.c1 = v[15:0];
    end
    r.found = 1'b1;
    r.chosen = best[3:0];
    return r;
  endfunction

  function automatic void store_word(item_t it);
    int f, w;
    f = it.fidx;
    w = it.widx;
    if (w == lfsc_pkg::W_RADIUS) rad_tab[f] = it.wval;
    else if (w < lfsc_pkg::W_NOMINAL) ctr_tab[f][w - lfsc_pkg::W_CENTER] = it.wval;
    else if (w < lfsc_pkg::W_GAIN) nom_tab[f][w - lfsc_pkg::W_NOMINAL] = it.wval;
    else if (w < lfsc_pkg::W_COST)
      gain_tab[f][(w - lfsc_pkg::W_GAIN) / 4][(w - lfsc_pkg::W_GAIN) % 4] = it.wval;
    else if (w < lfsc_pkg::W_TOTAL)
      cost_tab[f][(w - lfsc_pkg::W_COST) / 4][(w - lfsc_pkg::W_COST) % 4] = it.wval;
  endfunction

  function automatic logic [31:0] srand(int unsigned mag);
    return $urandom_range(0, 2 * mag) - mag;
  endfunction

  function automatic logic [31:0] plausible_word(int w);
    if (w == lfsc_pkg::W_RADIUS) return $urandom_range(1 << 16, 400 << 16);
    if (w < lfsc_pkg::W_NOMINAL) return srand(60 << 16);
    if (w < lfsc_pkg::W_GAIN) return srand(100 << 16);
    if (w < lfsc_pkg::W_COST) return srand(4 << 16);
    if ((w - lfsc_pkg::W_COST) % 5 == 0) return $urandom_range(256, 65536);
    return srand(256);
  endfunction

  function automatic item_t noise_item(logic cmd);
    item_t it;
    it = ItemW'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.cmd = cmd;
    return it;
  endfunction

  function automatic item_t aimed_step(int f, int unsigned spread);
    item_t  it;
    longint v;
    it = noise_item(lfsc_pkg::CMD_STEP);
    for (int i = 0; i < 4; i++) begin
      v = (longint'(ctr_tab[f][i]) >>> 8) + longint'($signed(srand(spread)));
      it.st[i] = v[15:0];
    end
    return it;
  endfunction

  function automatic item_t load_item(int f, int w, logic [31:0] val);
    item_t it;
    it = noise_item(lfsc_pkg::CMD_LOAD);
    it.fidx = 4'(f);
    it.widx = 5'(w);
    it.wval = val;
    return it;
  endfunction

  task automatic send_item(item_t it, bit has_exp = 0, result_t res = '0);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 20);
    end
    in_tvalid = 1'b1;
    in_tuser = it.cmd;
    in_tdata = {7'b0, it.sc[1], it.sc[0], it.st[3], it.st[2], it.st[1], it.st[0],
                it.wval, it.widx, it.fidx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    burst_left--;
    if (it.cmd == lfsc_pkg::CMD_STEP) begin
      control_q = {control_q, (has_exp ? res : predict_control(it))};
      item_cnt++;
    end else begin
      store_word(it);
      if (it.widx != lfsc_pkg::W_TOTAL) item_cnt++;
    end
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_cfg(int idx, int val);
    wait (control_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = 1'(idx);
    cfg_wdata = 5'(val);
    if (idx == lfsc_pkg::CFG_FUNNEL_COUNT) funnel_cnt = val;
    else pass_mode = val[0];
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void add_row(int kind, item_t it = '0, bit has_exp = 0,
                                  result_t res = '0, int aim = -1, int a = 0, int b = 0);
    row_t r;
    r.kind = kind;
    r.it = it;
    r.has_exp = has_exp;
    r.res = res;
    r.aim = aim;
    r.a = a;
    r.b = b;
    rows = {rows, r};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      result_t got, want;
      got = out_tdata[36:0];
      if (control_q.size() == 0) begin
        $error("result with none expected: %h", got);
        fail_cnt++;
      end else begin
        want = control_q.pop_front();
        if (got.c0 !== want.c0) begin
          $error("control_0: expected %h, actual %h", want.c0, got.c0);
          fail_cnt++;
        end
        if (got.c1 !== want.c1) begin
          $error("control_1: expected %h, actual %h", want.c1, got.c1);
          fail_cnt++;
        end
        if (got.found !== want.found) begin
          $error("found: expected %b, actual %b", want.found, got.found);
          fail_cnt++;
        end
        if (got.chosen !== want.chosen) begin
          $error("chosen_funnel: expected %0d, actual %0d", want.chosen, got.chosen);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int mode;
    out_tready = 1'b0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_tready = 1'b0;
        repeat (3000) @(negedge clk);
      end else begin
        if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
        case (mode)
          0: out_tready = 1'b1;
          1: out_tready = $urandom_range(0, 3) != 0;
          default: out_tready = $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  initial begin
    item_t   it;
    result_t res;
    int      n, ph;
    fail_cnt = 0;
    item_cnt = 0;
    hold_req = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    funnel_cnt = 0;
    pass_mode = 1;

    it = noise_item(lfsc_pkg::CMD_STEP);
    it.sc = {16'h8000, 16'h7fff};
    res = '{c0: 16'h7fff, c1: 16'h8000, found: 1'b0, chosen: 4'd0};
    add_row(ROW_STEP, it, 1, res);
    it.sc = {16'hffff, 16'h0000};
    res = '{c0: 16'h0000, c1: 16'hffff, found: 1'b0, chosen: 4'd0};
    add_row(ROW_STEP, it, 1, res);
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_PASSTHROUGH), .b(0));
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_FUNNEL_COUNT), .b(0));
    it.st = {16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
    add_row(ROW_STEP, it, 1, '0);
    add_row(ROW_LOAD, load_item(3, lfsc_pkg::W_TOTAL, 32'h8000_0001));
    add_row(ROW_FILL);
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_FUNNEL_COUNT), .b(1));
    add_row(ROW_STEP, .aim(0));
    it.st = {4{16'h7fff}};
    add_row(ROW_STEP, it);
    it.st = {4{16'h8000}};
    add_row(ROW_STEP, it);
    add_row(ROW_CLONE, .a(0), .b(1));
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_FUNNEL_COUNT), .b(2));
    add_row(ROW_STEP, .aim(0));
    add_row(ROW_LOAD, load_item(2, lfsc_pkg::W_RADIUS, 32'h7fff_ffff));
    add_row(ROW_LOAD, load_item(2, lfsc_pkg::W_NOMINAL, 32'h7fff_ffff));
    add_row(ROW_LOAD, load_item(2, lfsc_pkg::W_NOMINAL + 1, 32'h8000_0000));
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_FUNNEL_COUNT), .b(31));
    add_row(ROW_STEP, .aim(2));
    add_row(ROW_STEP, .aim(5));
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_FUNNEL_COUNT), .b(16));
    add_row(ROW_STEP, .aim(15));
    add_row(ROW_CFG, .a(lfsc_pkg::CFG_PASSTHROUGH), .b(1));
    add_row(ROW_STEP, noise_item(lfsc_pkg::CMD_STEP));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[r]) begin
      case (rows[r].kind)
        ROW_CFG: write_cfg(rows[r].a, rows[r].b);
        ROW_FILL: begin
          for (int f = 0; f < 16; f++) begin
            for (int w = 0; w < lfsc_pkg::W_TOTAL; w++) begin
              send_item(load_item(f, w, plausible_word(w)));
            end
          end
        end
        ROW_CLONE: begin
          for (int w = 0; w < lfsc_pkg::W_TOTAL; w++) begin
            it = load_item(rows[r].b, w, 0);
            if (w == lfsc_pkg::W_RADIUS) it.wval = rad_tab[rows[r].a];
            else if (w < lfsc_pkg::W_NOMINAL)
              it.wval = ctr_tab[rows[r].a][w - lfsc_pkg::W_CENTER];
            else if (w < lfsc_pkg::W_GAIN)
              it.wval = nom_tab[rows[r].a][w - lfsc_pkg::W_NOMINAL];
            else if (w < lfsc_pkg::W_COST)
              it.wval = gain_tab[rows[r].a][(w - lfsc_pkg::W_GAIN) / 4]
                                [(w - lfsc_pkg::W_GAIN) % 4];
            else
              it.wval = cost_tab[rows[r].a][(w - lfsc_pkg::W_COST) / 4]
                                [(w - lfsc_pkg::W_COST) % 4];
            send_item(it);
          end
        end
        default: begin
          it = rows[r].aim >= 0 ? aimed_step(rows[r].aim, 64) : rows[r].it;
          send_item(it, rows[r].has_exp, rows[r].res);
        end
      endcase
    end

    ph = 0;
    while (item_cnt < ItemTarget) begin
      n = $urandom_range(0, 9);
      n = n < 7 ? $urandom_range(1, 4) : (n == 7 ? 0 : (n == 8 ? 16 : $urandom_range(17, 31)));
      write_cfg(lfsc_pkg::CFG_FUNNEL_COUNT, n);
      write_cfg(lfsc_pkg::CFG_PASSTHROUGH, $urandom_range(0, 5) == 0);
      if (ph == 2) hold_req = 1;
      for (int k = 0; k < (n >= 16 ? 15 : 60); k++) begin
        case ($urandom_range(0, 9))
          0: send_item(noise_item(lfsc_pkg::CMD_STEP));
          1: send_item(noise_item(lfsc_pkg::CMD_LOAD));
          2, 3: begin
            it = load_item($urandom_range(0, 15), $urandom_range(0, 31), 0);
            it.wval = plausible_word(it.widx);
            send_item(it);
          end
          default: send_item(aimed_step($urandom_range(0, n == 0 ? 0 : (n > 16 ? 15 : n - 1)),
                                        $urandom_range(0, 3) == 0 ? 2048 : 256));
        endcase
      end
      ph++;
    end

    wait (control_q.size() == 0);
    repeat (SettleCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/lfsc_pkg.sv
sv/lqr_funnel_select_control.sv
tb/lqr_funnel_select_control_test.sv
